/* rtl/core/tcw_pkg.sv */
package tcw_pkg;

  // screen geometry defaults
  localparam int COLUMNS_DEFAULT = 80;
  localparam int LINES_DEFAULT   = 25;

  // field widths of the stream payload
  localparam int MODE_W       = 2;
  localparam int CHAR_W       = 8;
  localparam int CELL_INDEX_W = 11;
  localparam int CELL_W       = 16;
  localparam int ROW_OUT_W    = 5;
  localparam int COL_OUT_W    = 7;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 32;

  // mode codes on the input side
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // character codes and cell values
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h0A;
  localparam logic [CELL_W-1:0] RESET_BLANK  = {ATTR_RESET, SPACE_CODE};

  // work codes handed from front to back
  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } tcw_op_t;

  localparam int OP_W = $bits(tcw_op_t);

endpackage

/* rtl/core/text_console_writer.sv */
// channel  | dir | signals                       | payload
// ---------+-----+-------------------------------+-------------------------------------------
// s_axis   | in  | s_tvalid s_tready s_tdata/user | tuser mode, tdata char_code, cell_index
// m_axis   | out | m_tvalid m_tready m_tdata      | read_data, cursor_row, cursor_col, scrolled
// cfg      | in  | cfg_wen cfg_wdata              | text_attribute
//
// a put item is done in the back end's S_IDLE state unless it scrolls, a read also
// passes S_READ; clear blanks every cell in S_CLEAR, a scroll copies rows up in S_COPY
// and S_COPY_LAST and blanks the last row in S_BLANK; after reset all COLUMNS*LINES cells
// (2000 by default) are filled with blanks, and until that is done s_tready stays low
// front stage and a two-entry queue take items while the back end works or the
// result waits on m_tready
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int LINES   = tcw_pkg::LINES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // char_code [7:0], cell_index [18:8], zero fill
  input  logic [tcw_pkg::IN_DATA_W-1:0]     s_tdata,
  // mode [1:0]
  input  logic [tcw_pkg::MODE_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // read_data [15:0], cursor_row [20:16], cursor_col [27:21], scrolled [28], zero fill
  output logic [tcw_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_wen,
  input  logic [tcw_pkg::CHAR_W-1:0]        cfg_wdata
);

  localparam int AW = $clog2(COLUMNS * LINES);
  localparam int QW = tcw_pkg::OP_W + tcw_pkg::CHAR_W + AW;

  logic [tcw_pkg::CHAR_W-1:0] attr;
  logic                       init_done;
  logic                       f_valid;
  logic                       f_ready;
  tcw_pkg::tcw_op_t           f_op;
  logic [tcw_pkg::CHAR_W-1:0] f_char;
  logic [AW-1:0]              f_addr;
  logic                       q_valid;
  logic                       q_pop;
  logic [QW-1:0]              q_data;

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcw_pkg::ATTR_RESET;
    end else if (cfg_wen) begin
      attr <= cfg_wdata;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .enable    (init_done),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .s_mode    (s_tuser),
    .s_char    (s_tdata[tcw_pkg::CHAR_W-1:0]),
    .s_index   (s_tdata[tcw_pkg::CHAR_W +: tcw_pkg::CELL_INDEX_W]),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_op    (f_op),
    .cmd_char  (f_char),
    .cmd_addr  (f_addr)
  );

  tcw_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_op, f_char, f_addr}),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_data  (q_data)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .attr      (attr),
    .init_done (init_done),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd_op    (tcw_pkg::tcw_op_t'(q_data[QW-1 -: tcw_pkg::OP_W])),
    .cmd_char  (q_data[AW +: tcw_pkg::CHAR_W]),
    .cmd_addr  (q_data[AW-1:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

/* rtl/core/tcw_queue.sv */
module tcw_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic [DATA_W-1:0] slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // two-entry ring between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

/* rtl/core/tcw_front.sv */
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int LINES   = tcw_pkg::LINES_DEFAULT,
  localparam int CELL_COUNT = COLUMNS * LINES,
  localparam int AW = $clog2(CELL_COUNT)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              enable,
  input  logic                              s_valid,
  output logic                              s_ready,
  input  logic [tcw_pkg::MODE_W-1:0]        s_mode,
  input  logic [tcw_pkg::CHAR_W-1:0]        s_char,
  input  logic [tcw_pkg::CELL_INDEX_W-1:0]  s_index,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output tcw_pkg::tcw_op_t                  cmd_op,
  output logic [tcw_pkg::CHAR_W-1:0]        cmd_char,
  output logic [AW-1:0]                     cmd_addr
);

  localparam int IDXW = (AW > tcw_pkg::CELL_INDEX_W) ? AW : tcw_pkg::CELL_INDEX_W;

  logic              accept;
  logic [IDXW-1:0]   index_wide;
  logic              index_ok;
  tcw_pkg::tcw_op_t  op_next;

  assign s_ready    = enable && (!cmd_valid || cmd_ready);
  assign accept     = s_valid && s_ready;
  assign index_wide = IDXW'(s_index);
  assign index_ok   = (index_wide < IDXW'(CELL_COUNT));

  // classify the incoming item
  always_comb begin
    case (s_mode)
      tcw_pkg::MODE_PUT: begin
        op_next = (s_char == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE
                                                    : tcw_pkg::OP_CHAR;
      end
      tcw_pkg::MODE_CLEAR: begin
        op_next = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::MODE_READ: begin
        op_next = index_ok ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
      end
      default: begin
        op_next = tcw_pkg::OP_NOP;
      end
    endcase
  end

  // one staged command
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op   <= op_next;
      cmd_char <= s_char;
      cmd_addr <= AW'(index_wide);
    end
  end

endmodule

/* rtl/core/tcw_back.sv */
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int LINES   = tcw_pkg::LINES_DEFAULT,
  localparam int CELL_COUNT = COLUMNS * LINES,
  localparam int AW = $clog2(CELL_COUNT),
  localparam int RW = $clog2(LINES),
  localparam int CW = $clog2(COLUMNS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [tcw_pkg::CHAR_W-1:0]          attr,
  output logic                                init_done,
  input  logic                                cmd_valid,
  output logic                                cmd_pop,
  input  tcw_pkg::tcw_op_t                    cmd_op,
  input  logic [tcw_pkg::CHAR_W-1:0]          cmd_char,
  input  logic [AW-1:0]                       cmd_addr,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]      out_data
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_COPY,
    S_COPY_LAST,
    S_BLANK,
    S_CLEAR
  } state_t;

  localparam int PAD_W = tcw_pkg::OUT_DATA_W - tcw_pkg::CELL_W
                       - tcw_pkg::ROW_OUT_W - tcw_pkg::COL_OUT_W - 1;

  state_t                      state;
  logic [AW-1:0]               walk;
  logic [AW-1:0]               dst;
  logic                        pend;
  logic [RW-1:0]               row;
  logic [CW-1:0]               col;
  logic [tcw_pkg::CELL_W-1:0]  res_data;
  logic                        res_scrolled;

  logic [tcw_pkg::CELL_W-1:0]  mem [CELL_COUNT];
  logic [tcw_pkg::CELL_W-1:0]  mem_q;
  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [tcw_pkg::CELL_W-1:0]  mem_wd;
  logic [AW-1:0]               mem_ra;

  logic                        out_free;
  logic [AW-1:0]               cur_pos;
  logic [tcw_pkg::CELL_W-1:0]  blank;
  logic                        col_end;
  logic                        row_end;
  logic [tcw_pkg::ROW_OUT_W+RW-1:0] row_ext;
  logic [tcw_pkg::COL_OUT_W+CW-1:0] col_ext;

  assign out_free  = !out_valid || out_ready;
  assign cmd_pop   = (state == S_IDLE) && cmd_valid && out_free;
  assign init_done = (state != S_INIT);
  assign cur_pos   = AW'(row) * AW'(COLUMNS) + AW'(col);
  assign blank     = {attr, tcw_pkg::SPACE_CODE};
  assign col_end   = (col == CW'(COLUMNS - 1));
  assign row_end   = (row == RW'(LINES - 1));
  assign row_ext   = {{tcw_pkg::ROW_OUT_W{1'b0}}, row};
  assign col_ext   = {{tcw_pkg::COL_OUT_W{1'b0}}, col};
  assign out_data  = {{PAD_W{1'b0}}, res_scrolled,
                      col_ext[tcw_pkg::COL_OUT_W-1:0],
                      row_ext[tcw_pkg::ROW_OUT_W-1:0], res_data};

  // cell store port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = walk;
    mem_wd = blank;
    mem_ra = cmd_addr;
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wd = tcw_pkg::RESET_BLANK;
      end
      S_IDLE: begin
        if (cmd_pop && cmd_op == tcw_pkg::OP_CHAR) begin
          mem_we = 1'b1;
          mem_wa = cur_pos;
          mem_wd = {attr, cmd_char};
        end
      end
      S_COPY: begin
        mem_ra = AW'(walk + AW'(COLUMNS));
        mem_we = pend;
        mem_wa = dst;
        mem_wd = mem_q;
      end
      S_COPY_LAST: begin
        mem_we = 1'b1;
        mem_wa = dst;
        mem_wd = mem_q;
      end
      S_BLANK, S_CLEAR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // cell store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  // sequencer, cursor and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      walk      <= '0;
      pend      <= 1'b0;
      row       <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (walk == AW'(CELL_COUNT - 1)) begin
            walk  <= '0;
            state <= S_IDLE;
          end else begin
            walk <= walk + AW'(1);
          end
        end
        S_IDLE: begin
          if (cmd_pop) begin
            res_data     <= '0;
            res_scrolled <= 1'b0;
            walk         <= '0;
            pend         <= 1'b0;
            case (cmd_op)
              tcw_pkg::OP_CHAR, tcw_pkg::OP_NEWLINE: begin
                if (cmd_op == tcw_pkg::OP_CHAR && !col_end) begin
                  col       <= col + CW'(1);
                  out_valid <= 1'b1;
                end else begin
                  col <= '0;
                  if (row_end) begin
                    state <= S_COPY;
                  end else begin
                    row       <= row + RW'(1);
                    out_valid <= 1'b1;
                  end
                end
              end
              tcw_pkg::OP_CLEAR: begin
                row   <= '0;
                col   <= '0;
                state <= S_CLEAR;
              end
              tcw_pkg::OP_READ: begin
                state <= S_READ;
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          res_data  <= mem_q;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_COPY: begin
          pend <= 1'b1;
          dst  <= walk;
          if (walk == AW'(CELL_COUNT - COLUMNS - 1)) begin
            state <= S_COPY_LAST;
          end
          walk <= walk + AW'(1);
        end
        S_COPY_LAST: begin
          pend  <= 1'b0;
          state <= S_BLANK;
        end
        S_BLANK, S_CLEAR: begin
          if (walk == AW'(CELL_COUNT - 1)) begin
            res_scrolled <= (state == S_BLANK);
            out_valid    <= 1'b1;
            walk         <= '0;
            state        <= S_IDLE;
          end else begin
            walk <= walk + AW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  localparam int COLS  = COLUMNS_DEFAULT;
  localparam int ROWS  = LINES_DEFAULT;
  localparam int CELLS = COLS * ROWS;
  localparam int SW    = $clog2(CELLS);

  // mode code the block leaves unused
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int          IDLE_PCT    = 17;
  localparam int unsigned CYCLE_LIMIT = 12_000_000;
  localparam int          MAX_PRINTED = 40;

  typedef struct packed {
    logic [CELL_W-1:0]    read_data;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 scrolled;
  } console_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [MODE_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_wen;
  logic [CHAR_W-1:0]     cfg_wdata;

  // predicted console state
  logic [CELL_W-1:0] screen [CELLS];
  int                cur_row;
  int                cur_col;
  logic [CHAR_W-1:0] text_attr;

  console_result_t results_due [$];
  int              error_count;
  int unsigned     items_sent;
  int unsigned     cycle_count;
  bit              idling;

  text_console_writer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // console state model
  function automatic void reset_console_model();
    for (int i = 0; i < CELLS; i++) screen[SW'(i)] = RESET_BLANK;
    cur_row   = 0;
    cur_col   = 0;
    text_attr = ATTR_RESET;
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[SW'(i)] = {text_attr, SPACE_CODE};
  endfunction

  // move down one row, scrolling the screen past the bottom
  function automatic logic step_down_row();
    cur_row++;
    if (cur_row < ROWS) return 1'b0;
    for (int i = 0; i + COLS < CELLS; i++) screen[SW'(i)] = screen[SW'(i + COLS)];
    for (int i = CELLS - COLS; i < CELLS; i++) screen[SW'(i)] = {text_attr, SPACE_CODE};
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic console_result_t predict_console_result(
    logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch, logic [CELL_INDEX_W-1:0] idx);
    console_result_t r;
    r = '0;
    case (mode)
      MODE_PUT: begin
        if (ch == NEWLINE_CODE) begin
          cur_col    = 0;
          r.scrolled = step_down_row();
        end else begin
          screen[SW'(cur_row * COLS + cur_col)] = {text_attr, ch};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col    = 0;
            r.scrolled = step_down_row();
          end
        end
      end
      MODE_CLEAR: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      MODE_READ: begin
        if (idx < CELLS) r.read_data = screen[idx];
      end
      default: ;
    endcase
    r.row = cur_row[ROW_OUT_W-1:0];
    r.col = cur_col[COL_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("tb: mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  // one input transfer; leaves s_tvalid high at the following falling edge
  task automatic send_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                           logic [CELL_INDEX_W-1:0] idx);
    if (idling && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {{(IN_DATA_W - CELL_INDEX_W - CHAR_W){1'b0}}, idx, ch};
    do @(posedge clk); while (!s_tready);
    results_due.push_back(predict_console_result(mode, ch, idx));
    if (mode != MODE_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // stop sending until every outstanding result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
  endtask

  task automatic write_attribute(logic [CHAR_W-1:0] value);
    wait_drained();
    repeat (8) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    text_attr = value;
  endtask

  // result checker
  always @(posedge clk) begin
    console_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        want = results_due.pop_front();
        if (m_tdata[15:0] !== want.read_data)
          report_mismatch("read_data", 32'(m_tdata[15:0]), 32'(want.read_data));
        if (m_tdata[20:16] !== want.row)
          report_mismatch("cursor_row", 32'(m_tdata[20:16]), 32'(want.row));
        if (m_tdata[27:21] !== want.col)
          report_mismatch("cursor_col", 32'(m_tdata[27:21]), 32'(want.col));
        if (m_tdata[28] !== want.scrolled)
          report_mismatch("scrolled", 32'(m_tdata[28]), 32'(want.scrolled));
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_tready <= (idling && $urandom_range(0, 99) < IDLE_PCT) ? 1'b0 : 1'b1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // blank screen and home cursor straight after reset
  task automatic test_reset_state();
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'hFF, CELL_INDEX_W'(CELLS - 1));
  endtask

  // character extremes and newline
  task automatic test_put_extremes();
    send_item(MODE_PUT, 8'h00, 11'h7FF);
    send_item(MODE_PUT, 8'hFF, 11'h000);
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd1);
    send_item(MODE_PUT, NEWLINE_CODE, 11'h555);
    send_item(MODE_PUT, 8'h41, 11'h2AA);
    send_item(MODE_READ, 8'h00, CELL_INDEX_W'(COLS));
  endtask

  // reads past the store and the unused mode
  task automatic test_read_range();
    send_item(MODE_READ, 8'h00, CELL_INDEX_W'(CELLS));
    send_item(MODE_READ, 8'hFF, 11'h7FF);
    send_item(MODE_UNUSED, 8'hFF, 11'h7FF);
    send_item(MODE_UNUSED, NEWLINE_CODE, 11'd0);
  endtask

  task automatic test_clear_screen();
    send_item(MODE_CLEAR, 8'hFF, 11'h7FF);
    send_item(MODE_READ, 8'h00, 11'd0);
  endtask

  // attribute extremes on written and blanked cells
  task automatic test_attribute();
    write_attribute(8'h00);
    send_item(MODE_PUT, 8'h78, 11'd0);
    write_attribute(8'hFF);
    send_item(MODE_PUT, 8'h79, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd1);
    send_item(MODE_CLEAR, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, CELL_INDEX_W'(CELLS - 1));
  endtask

  // text lines, newline bursts and reads around the cursor
  task automatic test_random_text(int unsigned count);
    int unsigned start;
    int          pick;
    int          len;
    logic [CHAR_W-1:0]       ch;
    logic [CELL_INDEX_W-1:0] idx;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170) : $urandom_range(1, 20);
        for (int k = 0; k < len; k++) begin
          ch = ($urandom_range(0, 4) == 0) ? CHAR_W'($urandom_range(0, 255))
                                           : CHAR_W'($urandom_range(32, 126));
          send_item(MODE_PUT, ch, CELL_INDEX_W'($urandom_range(0, 2047)));
        end
        if ($urandom_range(0, 9) < 7)
          send_item(MODE_PUT, NEWLINE_CODE, CELL_INDEX_W'($urandom_range(0, 2047)));
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 9))
            0:       idx = CELL_INDEX_W'($urandom_range(CELLS, 2047));
            1, 2, 3: idx = CELL_INDEX_W'($urandom_range(0, CELLS - 1));
            default: idx = CELL_INDEX_W'(cur_row * COLS + $urandom_range(0, COLS - 1));
          endcase
          send_item(MODE_READ, CHAR_W'($urandom_range(0, 255)), idx);
        end
      end else if (pick < 80) begin
        send_item(MODE_UNUSED, CHAR_W'($urandom_range(0, 255)),
                  CELL_INDEX_W'($urandom_range(0, 2047)));
      end else if (pick < 83) begin
        send_item(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)),
                  CELL_INDEX_W'($urandom_range(0, 2047)));
      end else if (pick < 86) begin
        wait_drained();
      end else begin
        repeat ($urandom_range(1, 30))
          send_item(MODE_PUT, NEWLINE_CODE, CELL_INDEX_W'($urandom_range(0, 2047)));
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    m_tready    = 1'b0;
    cfg_wen     = 1'b0;
    cfg_wdata   = '0;
    error_count = 0;
    items_sent  = 0;
    cycle_count = 0;
    idling      = 1'b1;
    reset_console_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_put_extremes();
    test_read_range();
    test_clear_screen();
    test_attribute();

    write_attribute(CHAR_W'($urandom_range(0, 255)));
    test_random_text(300);
    write_attribute(8'hFF);
    test_random_text(300);
    // long stretch with no stalls on either side
    idling = 1'b0;
    write_attribute(CHAR_W'($urandom_range(0, 255)));
    test_random_text(300);
    idling = 1'b1;
    write_attribute(8'h00);
    test_random_text(300);

    wait_drained();
    repeat (40) @(posedge clk);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* text_console_writer.f */
rtl/core/tcw_pkg.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_front.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer.sv
sim/tb.sv
